/* rtl/tkk_pkg.sv */
package tkk_pkg;

	localparam int WinBytes  = 5;
	localparam int EscSeqNum = 31;
	localparam int SeqMax    = 4;

	localparam logic [2:0] CntMax = 3'd5;

	localparam logic [7:0] ChEsc   = 8'h1B;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChBs    = 8'h08;
	localparam logic [7:0] ChDel   = 8'h7F;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChCsi   = 8'h5B;
	localparam logic [7:0] ChSs3   = 8'h4F;
	localparam logic [7:0] Pad     = 8'h00;

	localparam logic [24:0] KsNone      = 25'h0;
	localparam logic [24:0] KsEscape    = 25'h00FF1B;
	localparam logic [24:0] KsReturn    = 25'h00FF0D;
	localparam logic [24:0] KsBackspace = 25'h00FF08;
	localparam logic [24:0] KsTab       = 25'h00FF09;
	localparam logic [24:0] KsNul       = 25'h00FF00;
	localparam logic [24:0] UniBase     = 25'h1000000;

	typedef logic [WinBytes-1:0][7:0] win_t;

	typedef struct packed {
		logic [24:0] key_code;
		logic [2:0]  used_count;
	} key_res_t;

	typedef struct packed {
		logic        hit;
		logic [15:0] sym;
		logic [2:0]  used;
	} esc_res_t;

	typedef struct packed {
		logic [2:0]               len;
		logic [0:SeqMax-1][7:0]   seq;
		logic [15:0]              sym;
	} esc_ent_t;

	localparam esc_ent_t EscTable [EscSeqNum] = '{
		'{3'd2, {"[", "A", Pad, Pad}, 16'hFF52},
		'{3'd2, {"[", "B", Pad, Pad}, 16'hFF54},
		'{3'd2, {"[", "C", Pad, Pad}, 16'hFF53},
		'{3'd2, {"[", "D", Pad, Pad}, 16'hFF51},
		'{3'd2, {"[", "H", Pad, Pad}, 16'hFF50},
		'{3'd2, {"[", "F", Pad, Pad}, 16'hFF57},
		'{3'd3, {"[", "1", "~", Pad}, 16'hFF50},
		'{3'd3, {"[", "4", "~", Pad}, 16'hFF57},
		'{3'd3, {"[", "2", "~", Pad}, 16'hFF63},
		'{3'd3, {"[", "3", "~", Pad}, 16'hFFFF},
		'{3'd3, {"[", "5", "~", Pad}, 16'hFF55},
		'{3'd3, {"[", "6", "~", Pad}, 16'hFF56},
		'{3'd3, {"[", "7", "~", Pad}, 16'hFF50},
		'{3'd3, {"[", "8", "~", Pad}, 16'hFF57},
		'{3'd4, {"[", "1", "1", "~"}, 16'hFFBE},
		'{3'd4, {"[", "1", "2", "~"}, 16'hFFBF},
		'{3'd4, {"[", "1", "3", "~"}, 16'hFFC0},
		'{3'd4, {"[", "1", "4", "~"}, 16'hFFC1},
		'{3'd4, {"[", "1", "5", "~"}, 16'hFFC2},
		'{3'd4, {"[", "1", "7", "~"}, 16'hFFC3},
		'{3'd4, {"[", "1", "8", "~"}, 16'hFFC4},
		'{3'd4, {"[", "1", "9", "~"}, 16'hFFC5},
		'{3'd4, {"[", "2", "0", "~"}, 16'hFFC6},
		'{3'd4, {"[", "2", "1", "~"}, 16'hFFC7},
		'{3'd4, {"[", "2", "3", "~"}, 16'hFFC8},
		'{3'd4, {"[", "2", "4", "~"}, 16'hFFC9},
		'{3'd2, {"O", "P", Pad, Pad}, 16'hFFBE},
		'{3'd2, {"O", "Q", Pad, Pad}, 16'hFFBF},
		'{3'd2, {"O", "R", Pad, Pad}, 16'hFFC0},
		'{3'd2, {"O", "S", Pad, Pad}, 16'hFFC1},
		'{3'd2, {"[", "Z", Pad, Pad}, 16'hFF09}
	};

endpackage

/* rtl/tkk_in_if.sv */
interface tkk_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_0;
	logic [7:0] byte_1;
	logic [7:0] byte_2;
	logic [7:0] byte_3;
	logic [7:0] byte_4;
	logic [2:0] avail_count;

	modport source (output valid, byte_0, byte_1, byte_2, byte_3, byte_4, avail_count,
		input ready);
	modport sink (input valid, byte_0, byte_1, byte_2, byte_3, byte_4, avail_count,
		output ready);
endinterface

/* rtl/tkk_out_if.sv */
interface tkk_out_if;
	logic        valid;
	logic        ready;
	logic [24:0] key_code;
	logic [2:0]  used_count;

	modport source (output valid, key_code, used_count, input ready);
	modport sink (input valid, key_code, used_count, output ready);
endinterface

/* rtl/tkk_esc_match.sv */
module tkk_esc_match (
	input  tkk_pkg::win_t     win,
	input  logic [2:0]        cnt,
	output tkk_pkg::esc_res_t res
);
	import tkk_pkg::*;

	logic [EscSeqNum-1:0] ent_hit;

	always_comb begin
		for (int i = 0; i < EscSeqNum; i++) begin
			ent_hit[i] = (cnt >= 3'(EscTable[i].len + 3'd1));
			for (int k = 0; k < SeqMax; k++) begin
				if (3'(k) < EscTable[i].len && win[k+1] != EscTable[i].seq[k])
					ent_hit[i] = 1'b0;
			end
		end
	end

	// lowest entry wins: walk from the top down
	always_comb begin
		res = '0;
		for (int i = EscSeqNum - 1; i >= 0; i--) begin
			if (ent_hit[i]) begin
				res.hit  = 1'b1;
				res.sym  = EscTable[i].sym;
				res.used = 3'(EscTable[i].len + 3'd1);
			end
		end
	end
endmodule

/* rtl/tkk_utf8_dec.sv */
module tkk_utf8_dec (
	input  tkk_pkg::win_t     win,
	input  logic [2:0]        cnt,
	output tkk_pkg::key_res_t res
);
	import tkk_pkg::*;

	logic [7:0]  lead;
	logic [2:0]  seq_len;
	logic        cont_ok;
	logic [20:0] cp;

	assign lead = win[0];

	always_comb begin
		seq_len = 3'd0;
		cp      = '0;
		if (lead[7:5] == 3'b110) begin
			seq_len = 3'd2;
			cp      = {10'd0, lead[4:0], win[1][5:0]};
		end else if (lead[7:4] == 4'b1110) begin
			seq_len = 3'd3;
			cp      = {5'd0, lead[3:0], win[1][5:0], win[2][5:0]};
		end else if (lead[7:3] == 5'b11110) begin
			seq_len = 3'd4;
			cp      = {lead[2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
		end
	end

	always_comb begin
		cont_ok = 1'b1;
		for (int k = 1; k < SeqMax; k++) begin
			if (3'(k) < seq_len && win[k][7:6] != 2'b10)
				cont_ok = 1'b0;
		end
	end

	always_comb begin
		res.key_code   = KsNone;
		res.used_count = 3'd1;
		if (seq_len != 3'd0 && cnt >= seq_len && cont_ok) begin
			res.used_count = seq_len;
			if (cp[20:8] == '0)
				res.key_code = {4'd0, cp};
			else
				res.key_code = UniBase + {4'd0, cp};
		end
	end
endmodule

/* rtl/terminal_key_to_keysym.sv */
// Terminal key decoder.
// key_in carries a window of the next five terminal bytes (byte_0 first) and
// avail_count, the number of those bytes that are valid (6 and 7 read as 5).
// key_out returns one keysym per window in key_code (0 for no key, an
// incomplete or unknown escape sequence, or broken UTF-8) and in used_count
// the number of bytes that key took from the front of the window.
// Both channels use valid/ready; an item moves on an edge where both are high.
// An accepted item goes into the input register, is decoded from there and
// moves on into the result register, which drives key_out and key_out.valid.
// One item is taken every cycle while key_out.ready stays
// high. When the receiver stalls, the result register holds its item and the
// input register can still take one more item before key_in.ready drops.
// Reset clears both valid flags; key_in.ready is high right after reset.
module terminal_key_to_keysym (
	input logic       clk,
	input logic       arst_n,
	tkk_in_if.sink    key_in,
	tkk_out_if.source key_out
);
	import tkk_pkg::*;

	logic     v_s1;
	win_t     win_s1;
	logic [2:0] cnt_s1;
	logic     v_s2;
	key_res_t res_s2;

	logic     load_s2;
	logic     load_s1;
	logic [2:0] cnt;
	esc_res_t esc_res;
	key_res_t utf_res;
	key_res_t res;

	assign load_s2      = !v_s2 || key_out.ready;
	assign key_in.ready = !v_s1 || load_s2;
	assign load_s1      = key_in.valid && key_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (key_in.ready)
				v_s1 <= key_in.valid;
			if (load_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			win_s1 <= {key_in.byte_4, key_in.byte_3, key_in.byte_2, key_in.byte_1,
				key_in.byte_0};
			cnt_s1 <= (key_in.avail_count > CntMax) ? CntMax : key_in.avail_count;
		end
		if (load_s2 && v_s1)
			res_s2 <= res;
	end

	assign cnt = cnt_s1;

	tkk_esc_match u_esc (
		.win (win_s1),
		.cnt (cnt),
		.res (esc_res)
	);

	tkk_utf8_dec u_utf8 (
		.win (win_s1),
		.cnt (cnt),
		.res (utf_res)
	);

	always_comb begin
		res.key_code   = KsNone;
		res.used_count = 3'd1;
		if (cnt != 3'd0) begin
			unique case (win_s1[0]) inside
				ChEsc: begin
					if (esc_res.hit) begin
						res.key_code   = {9'd0, esc_res.sym};
						res.used_count = esc_res.used;
					end else if (cnt >= 3'd2 && (win_s1[1] == ChEsc || win_s1[1] == ChCsi
						|| win_s1[1] == ChSs3)) begin
						res.key_code = KsNone;
					end else begin
						res.key_code = KsEscape;
					end
				end
				ChCr, ChLf:   res.key_code = KsReturn;
				ChBs, ChDel:  res.key_code = KsBackspace;
				ChTab:        res.key_code = KsTab;
				ChNul:        res.key_code = KsNul;
				[8'h80:8'hFF]: res = utf_res;
				default:      res.key_code = {17'd0, win_s1[0]};
			endcase
		end
	end

	assign key_out.valid      = v_s2;
	assign key_out.key_code   = res_s2.key_code;
	assign key_out.used_count = res_s2.used_count;
endmodule

/* rtl/tkk_checker.sv */
module tkk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [24:0] key_code,
	input logic [2:0]  used_count
);
	import tkk_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_code) && $stable(used_count))
		else $error("stalled result item changed");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> used_count >= 3'd1 && used_count <= CntMax)
		else $error("used_count out of range");

	a_escape_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_code == KsEscape |-> used_count == 3'd1)
		else $error("escape key must use one byte");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready |=> out_valid)
		else $error("accepted item did not reach output");
endmodule

bind terminal_key_to_keysym tkk_checker u_tkk_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (key_in.valid),
	.in_ready   (key_in.ready),
	.out_valid  (key_out.valid),
	.out_ready  (key_out.ready),
	.key_code   (key_out.key_code),
	.used_count (key_out.used_count)
);
